// ===== rtl/dtoi_pkg.sv =====
// shared types, character codes and helpers for the decimal text parser
`default_nettype none

package dtoi_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned MAG_W   = 63;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_LEAD   = 3'd0,
      PH_SIGN   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_TRAIL  = 3'd3,
      PH_FAIL   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              has_char;
      logic              end_of_text;
   } item_type;

   typedef struct packed {
      logic                      parse_ok;
      logic signed [VALUE_W-1:0] parsed_value;
   } result_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      is_blank = c inside {CHAR_SPACE, CHAR_TAB};
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/dtoi_req_if.sv =====
// text character channel: valid, ready and one character word
`default_nettype none

interface dtoi_req_if;
   logic                           valid;
   logic                           ready;
   logic [dtoi_pkg::CHAR_W-1:0]    char_code;
   logic                           has_char;
   logic                           end_of_text;

   modport source (output valid, output char_code, output has_char, output end_of_text,
                   input ready);
   modport sink (input valid, input char_code, input has_char, input end_of_text,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/dtoi_rsp_if.sv =====
// parse result channel: valid, ready and one result word
`default_nettype none

interface dtoi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  parse_ok;
   logic signed [dtoi_pkg::VALUE_W-1:0]   parsed_value;

   modport source (output valid, output parse_ok, output parsed_value, input ready);
   modport sink (input valid, input parse_ok, input parsed_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/decimal_text_to_int64.sv =====
// top level: signed decimal text to 64-bit integer parser
// a closing word's result passes through the input register, then is parsed into the
//   result register; other words give no result
// throughput: one character word per cycle with combinational shift-add digit update,
// but a closing word waits in the input register while an earlier result is not yet taken
// reset: synchronous, clears both valid flags and returns the parser to leading whitespace
`default_nettype none

module decimal_text_to_int64 (
   input wire logic    clock,
   input wire logic    reset,
   dtoi_req_if.sink    req_if,
   dtoi_rsp_if.source  rsp_if
);

   logic                 item_valid;
   dtoi_pkg::item_type   item;
   logic                 take;
   logic                 load;
   logic                 out_free;
   dtoi_pkg::result_type result;

   dtoi_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dtoi_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .load       (load),
      .result     (result)
   );

   dtoi_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .result   (result),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// ===== rtl/dtoi_in_stage.sv =====
// input register holding one character word ahead of the parser
`default_nettype none

module dtoi_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   dtoi_req_if.sink               req_if,
   input  wire logic              take,
   output      logic              item_valid,
   output      dtoi_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   dtoi_pkg::item_type item_ff;
   dtoi_pkg::item_type item_in;
   logic               accept;

   assign req_if.ready = !valid_ff || take;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff && !take;
      if (accept) begin
         item_in.char_code   = req_if.char_code;
         item_in.has_char    = req_if.has_char;
         item_in.end_of_text = req_if.end_of_text;
         valid_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/dtoi_parser.sv =====
// parse state machine, digit accumulators and result forming
`default_nettype none

module dtoi_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire dtoi_pkg::item_type  item,
   input  wire logic                out_free,
   output      logic                take,
   output      logic                load,
   output      dtoi_pkg::result_type result
);

   dtoi_pkg::phase_type               phase_ff;
   dtoi_pkg::phase_type               phase_in;
   dtoi_pkg::phase_type               phase_step;
   logic                              minus_ff;
   logic                              minus_in;
   logic                              minus_step;
   logic [dtoi_pkg::MAG_W-1:0]        acc_ff;
   logic [dtoi_pkg::MAG_W-1:0]        acc_in;
   logic [dtoi_pkg::MAG_W-1:0]        acc_step;
   // two's complement mirror of the magnitude, kept so no negate follows the add
   logic [dtoi_pkg::VALUE_W-1:0]      neg_ff;
   logic [dtoi_pkg::VALUE_W-1:0]      neg_in;
   logic [dtoi_pkg::VALUE_W-1:0]      neg_step;

   logic [dtoi_pkg::CHAR_W-1:0]       c;
   logic [dtoi_pkg::CHAR_W-1:0]       diff;
   logic [dtoi_pkg::DIGIT_W-1:0]      digit;
   logic [dtoi_pkg::MAG_W+3:0]        acc_x10;
   logic [dtoi_pkg::VALUE_W-1:0]      neg_x10;
   logic                              overflow;
   logic                              consume;
   logic                              do_digit;

   assign take    = item_valid && (!item.end_of_text || out_free);
   assign load    = take && item.end_of_text;
   assign consume = take && item.has_char;
   assign c       = item.char_code;
   assign diff    = c - dtoi_pkg::CHAR_ZERO;
   assign digit   = diff[dtoi_pkg::DIGIT_W-1:0];

   assign acc_x10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                  + {{dtoi_pkg::MAG_W{1'b0}}, digit};
   assign neg_x10 = {neg_ff[dtoi_pkg::VALUE_W-4:0], 3'b000}
                  + {neg_ff[dtoi_pkg::VALUE_W-2:0], 1'b0}
                  - {{(dtoi_pkg::VALUE_W-dtoi_pkg::DIGIT_W){1'b0}}, digit};
   // magnitude beyond 2^63-1 shows in the carry bits
   assign overflow = |acc_x10[dtoi_pkg::MAG_W+3:dtoi_pkg::MAG_W];

   // next phase
   always_comb begin
      phase_step = phase_ff;
      do_digit   = 1'b0;
      if (consume) begin
         case (phase_ff)
            dtoi_pkg::PH_LEAD: begin
               if (dtoi_pkg::is_blank(c)) begin
                  phase_step = dtoi_pkg::PH_LEAD;
               end else if (c inside {dtoi_pkg::CHAR_PLUS, dtoi_pkg::CHAR_MINUS}) begin
                  phase_step = dtoi_pkg::PH_SIGN;
               end else if (dtoi_pkg::is_digit(c)) begin
                  do_digit = 1'b1;
               end else begin
                  phase_step = dtoi_pkg::PH_FAIL;
               end
            end
            dtoi_pkg::PH_SIGN: begin
               if (dtoi_pkg::is_digit(c)) begin
                  do_digit = 1'b1;
               end else begin
                  phase_step = dtoi_pkg::PH_FAIL;
               end
            end
            dtoi_pkg::PH_DIGITS: begin
               if (dtoi_pkg::is_digit(c)) begin
                  do_digit = 1'b1;
               end else if (dtoi_pkg::is_blank(c)) begin
                  phase_step = dtoi_pkg::PH_TRAIL;
               end else begin
                  phase_step = dtoi_pkg::PH_FAIL;
               end
            end
            dtoi_pkg::PH_TRAIL: begin
               if (!dtoi_pkg::is_blank(c)) begin
                  phase_step = dtoi_pkg::PH_FAIL;
               end
            end
            default: begin
               phase_step = dtoi_pkg::PH_FAIL;
            end
         endcase
         if (do_digit) begin
            phase_step = overflow ? dtoi_pkg::PH_FAIL : dtoi_pkg::PH_DIGITS;
         end
      end
      phase_in = (load) ? dtoi_pkg::PH_LEAD : phase_step;
   end

   // accumulators, sign and result
   always_comb begin
      acc_step   = acc_ff;
      neg_step   = neg_ff;
      minus_step = minus_ff;
      if (consume && phase_ff == dtoi_pkg::PH_LEAD
          && (c inside {dtoi_pkg::CHAR_PLUS, dtoi_pkg::CHAR_MINUS})) begin
         minus_step = (c == dtoi_pkg::CHAR_MINUS);
      end
      if (do_digit && !overflow) begin
         acc_step = acc_x10[dtoi_pkg::MAG_W-1:0];
         neg_step = neg_x10;
      end
      result.parse_ok     = (phase_step == dtoi_pkg::PH_DIGITS)
                         || (phase_step == dtoi_pkg::PH_TRAIL);
      result.parsed_value = '0;
      if (result.parse_ok) begin
         result.parsed_value = minus_step ? neg_step : {1'b0, acc_step};
      end
      if (load) begin
         acc_in   = '0;
         neg_in   = '0;
         minus_in = 1'b0;
      end else begin
         acc_in   = acc_step;
         neg_in   = neg_step;
         minus_in = minus_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dtoi_pkg::PH_LEAD;
         minus_ff <= 1'b0;
         acc_ff   <= '0;
         neg_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dtoi_out_stage.sv =====
// result register that holds a finished word until the sink takes it
`default_nettype none

module dtoi_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire dtoi_pkg::result_type result,
   output      logic                 out_free,
   dtoi_rsp_if.source                rsp_if
);

   logic                 valid_ff;
   logic                 valid_in;
   dtoi_pkg::result_type result_ff;
   dtoi_pkg::result_type result_in;

   assign out_free = !valid_ff || rsp_if.ready;

   always_comb begin
      result_in = load ? result : result_ff;
      valid_in  = load || (valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.parse_ok     = result_ff.parse_ok;
   assign rsp_if.parsed_value = result_ff.parsed_value;

endmodule

`default_nettype wire

// ===== rtl/dtoi_checker.sv =====
// port-level checks for the parser top level, with the bind that attaches them
`default_nettype none

module dtoi_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic                                rsp_parse_ok,
   input wire logic signed [dtoi_pkg::VALUE_W-1:0] rsp_parsed_value
);

   localparam logic [dtoi_pkg::VALUE_W-1:0] MOST_NEG = {1'b1, {(dtoi_pkg::VALUE_W-1){1'b0}}};

   // a failed text reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_parse_ok |-> rsp_parsed_value == '0)
      else $error("failed parse with nonzero value");

   // magnitude never exceeds 2^63-1, so the most negative code never shows
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_parsed_value != MOST_NEG)
      else $error("result outside the symmetric range");

   // no result word survives a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_parse_ok)
         && $stable(rsp_parsed_value))
      else $error("stalled result word changed");

endmodule

bind decimal_text_to_int64 dtoi_checker u_dtoi_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_parse_ok     (rsp_if.parse_ok),
   .rsp_parsed_value (rsp_if.parsed_value)
);

`default_nettype wire

// ===== bench/decimal_text_to_int64_test.sv =====
// self-checking testbench for the decimal text to int64 parser
`timescale 1ns / 100ps

module decimal_text_to_int64_test;

   localparam logic [63:0] MAG_LIMIT = 64'h7fff_ffff_ffff_ffff;
   localparam longint VALUE_MAX = 64'h7fff_ffff_ffff_ffff;
   // DEL in a directed text stands for a NUL byte, which a string cannot hold
   localparam logic [dtoi_pkg::CHAR_W-1:0] NUL_STAND_IN = 8'h7f;
   localparam int TEXT_WORD_TARGET = 1400;
   localparam int LONG_STALL = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      string  text;
      bit     bare_close;
      bit     idle_between;
      bit     typed;
      bit     ok;
      longint value;
   } text_case_type;

   typedef struct {
      bit                   typed;
      dtoi_pkg::result_type want;
   } typed_answer_type;

   logic clock;
   logic reset;

   dtoi_req_if text_chan ();
   dtoi_rsp_if result_chan ();

   decimal_text_to_int64 i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (text_chan),
      .rsp_if (result_chan)
   );

   // parser state as the block should hold it
   dtoi_pkg::phase_type         text_phase = dtoi_pkg::PH_LEAD;
   logic                        text_negative = 1'b0;
   logic [dtoi_pkg::MAG_W-1:0]  text_magnitude = '0;

   dtoi_pkg::result_type awaited_parses[$];
   typed_answer_type     typed_answers[$];
   dtoi_pkg::item_type   text_words[$];

   int  error_count = 0;
   int  sent_words = 0;
   int  burst_left = 0;
   bit  gapless = 1'b0;
   bit  long_stall_pending = 1'b0;
   int  rx_cycle = 0;
   int  rx_mode = 0;
   int  quiet_cycles = 0;

   text_case_type text_cases [25] = '{
      '{"0",                        0, 0, 1, 1, 0},
      '{"9223372036854775807",      0, 0, 1, 1, VALUE_MAX},
      '{"-9223372036854775807",     0, 0, 1, 1, -VALUE_MAX},
      '{"9223372036854775808",      0, 0, 1, 0, 0},
      '{"-9223372036854775808",     0, 0, 1, 0, 0},
      '{"99999999999999999999",     0, 0, 1, 0, 0},
      '{"",                         1, 0, 1, 0, 0},
      '{" \t ",                     1, 0, 1, 0, 0},
      '{"-",                        0, 0, 1, 0, 0},
      '{"+",                        1, 0, 1, 0, 0},
      '{"- 5",                      0, 0, 1, 0, 0},
      '{"+-5",                      0, 0, 1, 0, 0},
      '{"12 3",                     0, 0, 1, 0, 0},
      '{"/",                        0, 0, 1, 0, 0},
      '{":",                        0, 0, 1, 0, 0},
      '{"4\177",                    0, 0, 1, 0, 0},
      '{"\377",                     0, 0, 1, 0, 0},
      '{"1x9",                      0, 0, 1, 0, 0},
      '{" \t+42\t ",                0, 0, 0, 0, 0},
      '{"-0",                       0, 0, 0, 0, 0},
      '{"000000000000000000000042", 0, 0, 0, 0, 0},
      '{"123",                      1, 0, 0, 0, 0},
      '{"\t-17 ",                   1, 0, 0, 0, 0},
      '{"5 \t",                     0, 0, 0, 0, 0},
      '{"-31",                      0, 1, 0, 0, 0}
   };

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic void note_error(input string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endfunction

   function automatic void add_digit(input logic [dtoi_pkg::CHAR_W-1:0] c);
      logic [63:0] d;
      logic [63:0] mag;
      d = {56'd0, c - dtoi_pkg::CHAR_ZERO};
      mag = {1'b0, text_magnitude};
      if (mag > (MAG_LIMIT - d) / 64'd10) begin
         text_phase = dtoi_pkg::PH_FAIL;
      end else begin
         mag = mag * 64'd10 + d;
         text_magnitude = mag[dtoi_pkg::MAG_W-1:0];
         text_phase = dtoi_pkg::PH_DIGITS;
      end
   endfunction

   function automatic void absorb_char(input logic [dtoi_pkg::CHAR_W-1:0] c);
      logic blank;
      logic digit;
      blank = c inside {dtoi_pkg::CHAR_SPACE, dtoi_pkg::CHAR_TAB};
      digit = c inside {[dtoi_pkg::CHAR_ZERO:dtoi_pkg::CHAR_NINE]};
      case (text_phase)
         dtoi_pkg::PH_LEAD: begin
            if (blank) begin
            end else if (c inside {dtoi_pkg::CHAR_PLUS, dtoi_pkg::CHAR_MINUS}) begin
               text_negative = (c == dtoi_pkg::CHAR_MINUS);
               text_phase = dtoi_pkg::PH_SIGN;
            end else if (digit) begin
               add_digit(c);
            end else begin
               text_phase = dtoi_pkg::PH_FAIL;
            end
         end
         dtoi_pkg::PH_SIGN: begin
            if (digit) add_digit(c);
            else text_phase = dtoi_pkg::PH_FAIL;
         end
         dtoi_pkg::PH_DIGITS: begin
            if (digit) add_digit(c);
            else if (blank) text_phase = dtoi_pkg::PH_TRAIL;
            else text_phase = dtoi_pkg::PH_FAIL;
         end
         dtoi_pkg::PH_TRAIL: begin
            if (!blank) text_phase = dtoi_pkg::PH_FAIL;
         end
         default: text_phase = dtoi_pkg::PH_FAIL;
      endcase
   endfunction

   // follows one accepted word; a closing word queues the parse it should give
   function automatic void follow_text_word(input dtoi_pkg::item_type w);
      dtoi_pkg::result_type r;
      typed_answer_type     ta;
      logic [63:0]          m;
      if (w.has_char) absorb_char(w.char_code);
      if (w.end_of_text) begin
         m = {1'b0, text_magnitude};
         if (text_phase == dtoi_pkg::PH_DIGITS || text_phase == dtoi_pkg::PH_TRAIL) begin
            r.parse_ok = 1'b1;
            r.parsed_value = text_negative ? 64'd0 - m : m;
         end else begin
            r = '0;
         end
         text_phase = dtoi_pkg::PH_LEAD;
         text_negative = 1'b0;
         text_magnitude = '0;
         if (typed_answers.size() != 0) begin
            ta = typed_answers.pop_front();
            if (ta.typed) r = ta.want;
         end
         awaited_parses.push_back(r);
      end
   endfunction

   always @(posedge clock) begin : watch_channels
      dtoi_pkg::item_type   w;
      dtoi_pkg::result_type got;
      dtoi_pkg::result_type want;
      if (!reset) begin
         if (text_chan.valid && text_chan.ready) begin
            w.char_code = text_chan.char_code;
            w.has_char = text_chan.has_char;
            w.end_of_text = text_chan.end_of_text;
            follow_text_word(w);
         end
         if (result_chan.valid && result_chan.ready) begin
            got.parse_ok = result_chan.parse_ok;
            got.parsed_value = result_chan.parsed_value;
            if (awaited_parses.size() == 0) begin
               note_error($sformatf("unexpected result: parse_ok %0b value %0d",
                                    got.parse_ok, got.parsed_value));
            end else begin
               want = awaited_parses.pop_front();
               if (got.parse_ok !== want.parse_ok)
                  note_error($sformatf("parse_ok mismatch: expected %0b actual %0b",
                                       want.parse_ok, got.parse_ok));
               if (got.parsed_value !== want.parsed_value)
                  note_error($sformatf("parsed_value mismatch: expected %0d actual %0d",
                                       want.parsed_value, got.parsed_value));
            end
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (text_chan.valid && text_chan.ready)
          || (result_chan.valid && result_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: stall pattern picked at random from four modes, plus one long hold-off
   initial begin
      result_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
         if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            result_chan.ready <= 1'b0;
            repeat (LONG_STALL - 1) @(negedge clock);
         end else begin
            case (rx_mode)
               0: result_chan.ready <= 1'b1;
               1: result_chan.ready <= 1'($urandom_range(0, 1));
               2: result_chan.ready <= ($urandom_range(0, 3) == 0);
               default: result_chan.ready <= ((rx_cycle % 7) < 4);
            endcase
         end
      end
   end

   function automatic void add_char(input logic [dtoi_pkg::CHAR_W-1:0] c);
      dtoi_pkg::item_type w;
      w.char_code = c;
      w.has_char = 1'b1;
      w.end_of_text = 1'b0;
      text_words.push_back(w);
   endfunction

   function automatic dtoi_pkg::item_type idle_word();
      dtoi_pkg::item_type w;
      w.char_code = 8'($urandom_range(0, 255));
      w.has_char = 1'b0;
      w.end_of_text = 1'b0;
      return w;
   endfunction

   function automatic void close_text(input bit bare);
      dtoi_pkg::item_type w;
      if (!bare && text_words.size() != 0) begin
         w = text_words.pop_back();
      end else begin
         w = idle_word();
      end
      w.end_of_text = 1'b1;
      text_words.push_back(w);
   endfunction

   function automatic logic [dtoi_pkg::CHAR_W-1:0] random_blank();
      return $urandom_range(0, 1) ? dtoi_pkg::CHAR_SPACE : dtoi_pkg::CHAR_TAB;
   endfunction

   task automatic build_random_text();
      int                 kind;
      int                 pick;
      int                 pos;
      logic [63:0]        mag;
      string              digits;
      dtoi_pkg::item_type w;
      text_words.delete();
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
         repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) add_char(random_blank());
         pick = $urandom_range(0, 2);
         if (pick == 1) add_char(dtoi_pkg::CHAR_PLUS);
         else if (pick == 2) add_char(dtoi_pkg::CHAR_MINUS);
         case ($urandom_range(0, 9))
            0: mag = 64'($urandom_range(0, 99));
            5: mag = MAG_LIMIT - $urandom_range(0, 20);
            6: mag = MAG_LIMIT + 64'd1 + $urandom_range(0, 20);
            7: mag = '1 - $urandom_range(0, 20);
            default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
         endcase
         digits = $sformatf("%0d", mag);
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 6)) digits = {"0", digits};
            1: begin
               digits = "";
               repeat ($urandom_range(19, 22))
                  digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
            end
            default: ;
         endcase
         for (int k = 0; k < digits.len(); k++) add_char(digits[k]);
         repeat ($urandom_range(0, 3)) add_char(random_blank());
         // broken texts: a bad byte, a stray sign or blank, or nothing but a few blanks or none
         if (kind >= 70) begin
            case ($urandom_range(0, 3))
               0: begin
                  pos = $urandom_range(0, text_words.size() - 1);
                  w = text_words[pos];
                  w.char_code = 8'($urandom_range(0, 255));
                  text_words[pos] = w;
               end
               1: begin
                  w = text_words[0];
                  w.char_code = $urandom_range(0, 1) ? dtoi_pkg::CHAR_PLUS
                                                     : dtoi_pkg::CHAR_MINUS;
                  text_words.insert($urandom_range(0, text_words.size()), w);
               end
               2: begin
                  w = text_words[0];
                  w.char_code = random_blank();
                  text_words.insert($urandom_range(0, text_words.size()), w);
               end
               default: begin
                  text_words.delete();
                  repeat ($urandom_range(0, 2)) add_char(random_blank());
               end
            endcase
         end
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            text_words.insert($urandom_range(0, text_words.size()), idle_word());
      close_text(1'($urandom_range(0, 1)));
   endtask

   task automatic send_word(input dtoi_pkg::item_type w);
      if (!gapless) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 10)) begin
               @(negedge clock);
               text_chan.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 40);
         end
         burst_left--;
      end
      @(negedge clock);
      text_chan.valid <= 1'b1;
      text_chan.char_code <= w.char_code;
      text_chan.has_char <= w.has_char;
      text_chan.end_of_text <= w.end_of_text;
      do @(posedge clock); while (!text_chan.ready);
      if (w.has_char || w.end_of_text) sent_words++;
   endtask

   task automatic send_text(input bit typed, input dtoi_pkg::result_type want);
      typed_answer_type ta;
      ta.typed = typed;
      ta.want = want;
      typed_answers.push_back(ta);
      foreach (text_words[i]) send_word(text_words[i]);
   endtask

   initial begin
      dtoi_pkg::result_type want;
      logic [7:0]           c;
      text_chan.valid = 1'b0;
      text_chan.char_code = '0;
      text_chan.has_char = 1'b0;
      text_chan.end_of_text = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (text_cases[r]) begin
         text_words.delete();
         for (int k = 0; k < text_cases[r].text.len(); k++) begin
            c = text_cases[r].text[k];
            add_char(c == NUL_STAND_IN ? 8'h00 : c);
            if (text_cases[r].idle_between) text_words.push_back(idle_word());
         end
         close_text(text_cases[r].bare_close);
         want.parse_ok = text_cases[r].ok;
         want.parsed_value = text_cases[r].value;
         send_text(text_cases[r].typed, want);
      end

      // receiver holds off while short texts keep coming, so the input backs up
      long_stall_pending = 1'b1;
      gapless = 1'b1;
      repeat (40) begin
         text_words.delete();
         add_char(dtoi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         close_text(1'b0);
         send_text(1'b0, '0);
      end
      gapless = 1'b0;

      while (sent_words < TEXT_WORD_TARGET) begin
         build_random_text();
         send_text(1'b0, '0);
      end
      @(negedge clock);
      text_chan.valid <= 1'b0;

      while (awaited_parses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
